[rtl/core/qsu_pkg.sv]
package qsu_pkg;

  // Result status codes
  localparam logic [1:0] STAT_RUN   = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_NOQ   = 2'd2;
  localparam logic [1:0] STAT_UNTRM = 2'd3;

  // Characters the decoder looks at
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // Register map
  localparam logic REG_QUOTE_STYLE = 1'b0;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Full escape table of double-quote style
  function automatic logic [7:0] full_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_N:    r = CH_LF;
      CH_R:    r = CH_CR;
      CH_T:    r = CH_TAB;
      CH_B:    r = CH_BS;
      CH_F:    r = CH_FF;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/qsu_decode.sv]
module qsu_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  logic          quote_style,
  output qsu_pkg::res_t res0,
  output qsu_pkg::res_t res1,
  output logic [1:0]    res_count
);
  import qsu_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_RSVD = 2'd3
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] quote_ch;
  logic       is_space;

  function automatic res_t mk(input logic v, input logic [7:0] b, input logic [1:0] s,
                              input logic l);
    res_t r;
    r.byte_valid   = v;
    r.decoded_byte = b;
    r.status       = s;
    r.last         = l;
    return r;
  endfunction

  assign quote_ch = quote_style ? CH_SQUOTE : CH_DQUOTE;
  assign is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                    (text_byte == CH_LF) || (text_byte == CH_CR);

  always_comb begin
    res0       = mk(1'b0, 8'h00, STAT_RUN, 1'b1);
    res1       = mk(1'b0, 8'h00, STAT_RUN, 1'b1);
    res_count  = 2'd0;
    phase_next = phase;
    unique case (phase)
      PH_BODY: begin
        if (end_of_text) begin
          res0       = mk(1'b0, 8'h00, STAT_UNTRM, 1'b1);
          res_count  = 2'd1;
          phase_next = PH_SKIP;
        end else if (text_byte == quote_ch) begin
          res0       = mk(1'b0, 8'h00, STAT_DONE, 1'b1);
          res_count  = 2'd1;
          phase_next = PH_SKIP;
        end else if (text_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else begin
          res0      = mk(1'b1, text_byte, STAT_RUN, 1'b1);
          res_count = 2'd1;
        end
      end
      PH_ESC: begin
        if (end_of_text) begin
          res0       = mk(1'b1, CH_BSLASH, STAT_RUN, 1'b0);
          res1       = mk(1'b0, 8'h00, STAT_UNTRM, 1'b1);
          res_count  = 2'd2;
          phase_next = PH_SKIP;
        end else begin
          phase_next = PH_BODY;
          if (!quote_style) begin
            res0      = mk(1'b1, full_escape(text_byte), STAT_RUN, 1'b1);
            res_count = 2'd1;
          end else if (text_byte == CH_SQUOTE || text_byte == CH_BSLASH) begin
            res0      = mk(1'b1, text_byte, STAT_RUN, 1'b1);
            res_count = 2'd1;
          end else begin
            res0      = mk(1'b1, CH_BSLASH, STAT_RUN, 1'b0);
            res1      = mk(1'b1, text_byte, STAT_RUN, 1'b1);
            res_count = 2'd2;
          end
        end
      end
      default: begin
        // skip whitespace; the unused code behaves the same
        phase_next = PH_SKIP;
        if (end_of_text) begin
          res0      = mk(1'b0, 8'h00, STAT_NOQ, 1'b1);
          res_count = 2'd1;
        end else if (is_space) begin
          res_count = 2'd0;
        end else if (text_byte == quote_ch) begin
          phase_next = PH_BODY;
        end else begin
          res0      = mk(1'b0, 8'h00, STAT_NOQ, 1'b1);
          res_count = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

endmodule

[rtl/core/qsu_out_buf.sv]
module qsu_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  qsu_pkg::res_t push0,
  input  qsu_pkg::res_t push1,
  input  logic [1:0]    push_count,
  input  logic          push_req,
  output logic          push_room,
  output logic          out_valid,
  input  logic          out_ready,
  output qsu_pkg::res_t head
);
  import qsu_pkg::*;

  res_t       slot0;
  res_t       slot1;
  res_t       slot0_next;
  res_t       slot1_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] cnt_kept;
  logic       pop;
  logic       push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign head      = slot0;
  assign cnt_kept  = cnt - {1'b0, pop};

  always_comb begin
    case (cnt_kept)
      2'd0:    push_room = 1'b1;
      2'd1:    push_room = (push_count != 2'd2);
      default: push_room = (push_count == 2'd0);
    endcase
  end

  assign push = push_req && push_room;

  always_comb begin
    // drop the head on a pop, then append what the decoder hands over
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    case (cnt_kept)
      2'd0: begin
        slot0_next = push0;
        slot1_next = push1;
      end
      2'd1: begin
        slot1_next = push0;
      end
      default: begin
        slot1_next = slot1;
      end
    endcase
    cnt_next = push ? (cnt_kept + push_count) : cnt_kept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    if (push || pop) begin
      slot0 <= slot0_next;
      slot1 <= slot1_next;
    end
  end

endmodule

[rtl/core/quoted_string_unescaper.sv]
// Quoted string unescaper. Takes text one byte per request (or an end-of-text
// mark with end_of_text high), skips leading space, tab, LF and CR, expects the
// opening quote that quote_style selects (register 0 at byte address 0: 0 for
// double quotes with escapes \n \r \t \b \f \" \\ \/, 1 for single quotes where
// only \' and \\ are escapes), and returns the decoded content one byte per
// result. A result carries byte_valid, decoded_byte, status (0 running,
// 1 string complete, 2 no opening quote, 3 unterminated) and last, which marks
// the final result of one input. Each input gives zero, one or two results;
// after a non-running status the block goes back to skipping whitespace.
// Rate: one input per clock when its results fit the queue. The decoder works
// on an input held in the input register; its results then enter the queue
// behind out_valid. The result side sets the pace: results leave one per clock
// through a two-entry queue while out_ready is high, and the input register
// holds its request whenever the queue cannot take all its results (two results
// meeting an undrained one, or a full queue and a stalled receiver). Freed
// space counts in that cycle; in_ready follows out_ready combinationally. The
// user must change configuration only while idle; it is not enforced.
module quoted_string_unescaper (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  decoded_byte,
  output logic [1:0]  status,
  output logic        last
);
  import qsu_pkg::*;

  logic       quote_style;
  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_end;
  logic       advance;
  logic       push_room;
  logic [1:0] res_count;
  res_t       res0;
  res_t       res1;
  res_t       head;

  // Configuration: a single one-bit register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUOTE_STYLE) ? {31'd0, quote_style} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_style <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_QUOTE_STYLE)) begin
      quote_style <= pwdata[0];
    end
  end

  // Input register: the held request advances once its results fit the queue
  assign advance  = item_valid && push_room;
  assign in_ready = !item_valid || push_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_byte <= text_byte;
      item_end  <= end_of_text;
    end
  end

  qsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .text_byte   (item_byte),
    .end_of_text (item_end),
    .quote_style (quote_style),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  qsu_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (res_count),
    .push_req   (item_valid),
    .push_room  (push_room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  assign byte_valid   = head.byte_valid;
  assign decoded_byte = head.decoded_byte;
  assign status       = head.status;
  assign last         = head.last;

endmodule
